FILE: sv/htwd_pkg.sv
// Package for the Huffman tree-walk decoder: field widths, command and
// register codes, and the layout of one node table entry.
// No dependencies.
`timescale 1ns / 1ps

package htwd_pkg;

   localparam int IDX_W       = 10;
   localparam int SYM_W       = 9;
   localparam int BYTE_W      = 8;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int BIT_CNT_W   = 4;
   localparam int NODE_COUNT_DEF = 1024;

   // Request commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_ROOT_INDEX = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_EOF_SYMBOL = 1'b1;

   // One node table entry, 30 bits
   typedef struct packed {
      logic             leaf;
      logic [SYM_W-1:0] symbol;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } node_type;

endpackage

FILE: sv/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder top level: node table memory, bit-serial walk
// sequencer, one-deep result holding register.
// Depends on htwd_pkg.
`timescale 1ns / 1ps

// Usage:
//   Requests are taken when start is high and busy is low. A load request
//   (req_cmd = load) writes one node and restarts the walk at the root; it
//   leaves busy low and returns nothing, as does a byte after end of stream.
//   A decode request shifts the byte out MSB first.
//   While busy, a decode uses the current entry, reads one child entry per
//   bit, re-reads the root after each leaf found before the eighth bit, and
//   ends in a flush state; the end-of-stream leaf stops it early. The next
//   request is taken at the end of the first idle cycle, so bytes never
//   overlap on the single read port of the node table.
//   Results come on rsp_symbol / rsp_is_eof / rsp_last with rsp_valid high
//   for exactly one cycle. Each result leaves one leaf later than it is found
//   so that rsp_last can be marked; the final one is on the ports in the
//   first idle cycle after the flush. The receiver cannot stall the outputs.
//   Reset clears the walk (at root, position 0), the end-of-stream flag and
//   the registers (root_index 0, eof_symbol 256). Table contents are not
//   cleared and must be loaded before use.
module huffman_tree_walk_decoder
   import htwd_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [IDX_W-1:0]      req_node_index,
   input  logic                  req_node_leaf,
   input  logic [SYM_W-1:0]      req_node_symbol,
   input  logic [IDX_W-1:0]      req_left_child,
   input  logic [IDX_W-1:0]      req_right_child,
   input  logic [BYTE_W-1:0]     req_data_byte,
   // result channel
   output logic                  rsp_valid,
   output logic [SYM_W-1:0]      rsp_symbol,
   output logic                  rsp_is_eof,
   output logic                  rsp_last,
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CUR   = 2'd1;
   localparam logic [1:0] ST_CHILD = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     root_index_ff;
   logic [SYM_W-1:0]     eof_symbol_ff;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic                 at_root_ff, at_root_in;
   logic                 done_ff, done_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]     nxt_ff, nxt_in;

   // pending result, held until it is known whether it is the last
   logic                 pend_ff, pend_in;
   logic [SYM_W-1:0]     pend_sym_ff, pend_sym_in;
   logic                 pend_eof_ff, pend_eof_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_is_eof_ff, rsp_is_eof_in;
   logic                 rsp_last_ff, rsp_last_in;

   // node table
   node_type             mem [NODE_COUNT];
   node_type             rd_ff;
   logic                 rd_ok_ff;
   logic [IDX_W-1:0]     rd_idx;
   logic                 rd_ok;
   node_type             node;

   logic                 accept;
   logic                 wr_en;
   logic                 wr_ok;
   logic [IDX_W-1:0]     step_idx;
   logic                 is_eof_leaf;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign wr_ok  = (32'(req_node_index) < 32'(NODE_COUNT));
   assign wr_en  = accept && (req_cmd == CMD_LOAD) && wr_ok;
   assign rd_ok  = (32'(rd_idx) < 32'(NODE_COUNT));

   // out-of-range reads see an all-zero entry
   assign node        = rd_ok_ff ? rd_ff : '0;
   assign step_idx    = shift_ff[BYTE_W-1] ? node.right : node.left;
   assign is_eof_leaf = node.leaf && (node.symbol == eof_symbol_ff);

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_node_index)] <= '{leaf:   req_node_leaf,
                                       symbol: req_node_symbol,
                                       left:   req_left_child,
                                       right:  req_right_child};
      end
      rd_ff    <= mem[AW'(rd_idx)];
      rd_ok_ff <= rd_ok;
   end

   // Read address selection
   always_comb begin
      rd_idx = '0;
      unique case (state_ff)
         ST_IDLE:  rd_idx = at_root_ff ? root_index_ff : pos_ff;
         ST_CUR:   rd_idx = step_idx;
         ST_CHILD: rd_idx = node.leaf ? root_index_ff : step_idx;
         ST_FLUSH: rd_idx = '0;
         default:  rd_idx = '0;
      endcase
   end

   // Walk sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      at_root_in    = at_root_ff;
      done_in       = done_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      nxt_in        = nxt_ff;
      pend_in       = pend_ff;
      pend_sym_in   = pend_sym_ff;
      pend_eof_in   = pend_eof_ff;
      rsp_valid_in  = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_is_eof_in = rsp_is_eof_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  done_in    = 1'b0;
                  at_root_in = 1'b1;
                  pos_in     = '0;
               end else if (!done_ff) begin
                  shift_in = req_data_byte;
                  cnt_in   = BIT_CNT_W'(BYTE_W);
                  state_in = ST_CUR;
               end
            end
         end
         ST_CUR: begin
            // current entry is here: take one bit toward a child
            nxt_in   = step_idx;
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff - 1'b1;
            state_in = ST_CHILD;
         end
         ST_CHILD: begin
            pos_in     = nxt_ff;
            at_root_in = 1'b0;
            if (node.leaf) begin
               at_root_in = 1'b1;
               pos_in     = '0;
               // older pending result is not the last one
               if (pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_symbol_in = pend_sym_ff;
                  rsp_is_eof_in = pend_eof_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_in     = 1'b1;
               pend_sym_in = is_eof_leaf ? '0 : node.symbol;
               pend_eof_in = is_eof_leaf;
            end
            if (node.leaf && is_eof_leaf) begin
               done_in  = 1'b1;
               state_in = ST_FLUSH;
            end else if (cnt_ff == '0) begin
               state_in = ST_FLUSH;
            end else if (node.leaf) begin
               state_in = ST_CUR;
            end else begin
               // child entry is the new current entry: step again
               nxt_in   = step_idx;
               shift_in = shift_ff << 1;
               cnt_in   = cnt_ff - 1'b1;
            end
         end
         ST_FLUSH: begin
            if (pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = pend_sym_ff;
               rsp_is_eof_in = pend_eof_ff;
               rsp_last_in   = 1'b1;
            end
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         at_root_ff    <= 1'b1;
         done_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         root_index_ff <= '0;
         eof_symbol_ff <= SYM_W'(256);
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         at_root_ff   <= at_root_in;
         done_ff      <= done_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               REG_ROOT_INDEX: root_index_ff <= csr_wdata;
               REG_EOF_SYMBOL: eof_symbol_ff <= csr_wdata[SYM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      cnt_ff        <= cnt_in;
      nxt_ff        <= nxt_in;
      pend_sym_ff   <= pend_sym_in;
      pend_eof_ff   <= pend_eof_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_is_eof_ff <= rsp_is_eof_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_is_eof = rsp_is_eof_ff;
   assign rsp_last   = rsp_last_ff;

   // End marker carries a zero symbol and closes the byte
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_eof |-> rsp_last && (rsp_symbol == '0))
      else $error("end marker not last or symbol nonzero");

   // Reaching the end-of-stream leaf stops the walk and flushes
   a_eof_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHILD) && node.leaf && is_eof_leaf
      |=> (state_ff == ST_FLUSH) && done_ff)
      else $error("walk did not stop at end-of-stream leaf");

   // Flush always returns to idle with nothing pending
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |=> (state_ff == ST_IDLE) && !pend_ff)
      else $error("flush did not finish");

   // A decode request after end of stream produces no work
   a_done_drop: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_DECODE) && done_ff |=> state_ff == ST_IDLE)
      else $error("byte decoded after end of stream");

endmodule
